// File: sv/sitda_pkg.sv
// Shared types, constants and helper functions of the signed integer to decimal text unit.
package sitda_pkg;

  localparam int VALUE_BITS = 32;

  // Number of decimal digits needed for the largest magnitude, 2^(bits-1).
  function automatic int digits_for(int bits);
    logic [127:0] v;
    int           n;
    v = 128'd1 << (bits - 1);
    n = 0;
    for (int i = 0; i < 40; i++) begin
      if (v != 128'd0) begin
        v = v / 10;
        n++;
      end
    end
    return n;
  endfunction

  localparam int NUM_DIGITS      = digits_for(VALUE_BITS);
  localparam int BCD_W           = 4 * NUM_DIGITS;
  localparam int DIG_IW          = $clog2(NUM_DIGITS);
  localparam int STEPS_PER_STAGE = 8;
  localparam int DD_STAGES       = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int CHAR_W          = 6;

  typedef logic [VALUE_BITS-1:0]       value_t;
  typedef logic [NUM_DIGITS-1:0][3:0]  bcd_t;
  typedef logic [CHAR_W-1:0]           char_t;

  localparam char_t CHAR_MINUS = 6'd45;
  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_NINE  = 6'd57;

  // One double-dabble step: add 3 to every digit of 5 or more, then shift in one bit.
  function automatic bcd_t dd_step(bcd_t bcd, logic b);
    bcd_t             adj;
    logic [BCD_W-1:0] flat;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    flat = adj;
    flat = {flat[BCD_W-2:0], b};
    return flat;
  endfunction

endpackage

// File: sv/sitda_if.sv
// Handshake channels of the unit: integer input and character output.
interface sitda_in_if;
  logic               valid;
  logic               ready;
  sitda_pkg::value_t  value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic              valid;
  logic              ready;
  sitda_pkg::char_t  char_code;
  logic              last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: sv/signed_int_to_decimal_ascii_unit.sv
// Top level: signed integer to decimal ASCII text, pipelined conversion plus character serializer.
//
// Each accepted integer is printed as decimal text, one character per output item, most
// significant first: a '-' for negative values, then the digits without leading zeros
// ('0' for zero); last_char marks the final character. The magnitude is converted in a
// pipeline of one sign/negate stage and DD_STAGES double-dabble stages (4 for 32 bits,
// 8 shift steps each); a new integer may enter every cycle until the pipeline fills. The
// serializer emits one character per cycle while the output is not stalled; a number has
// 1 to 11 characters. The serializer takes the next number in the cycle it sends the
// previous number's last character.
module signed_int_to_decimal_ascii_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  sitda_in_if.sink     in_i,
  sitda_out_if.source  out_o
);

  localparam int DD = sitda_pkg::DD_STAGES;

  // Conversion pipeline: stage 0 holds sign and magnitude, stages 1..DD run double dabble.
  logic [DD:0]        vld_q;
  logic [DD:0]        stg_rdy;
  logic               neg_q [0:DD];
  sitda_pkg::value_t  bin_q [0:DD];
  sitda_pkg::bcd_t    bcd_q [1:DD];

  // Serializer and output register
  logic                           busy_q;
  logic                           neg_pend_q;
  sitda_pkg::bcd_t                dig_q;
  logic [sitda_pkg::DIG_IW-1:0]   pos_q;
  logic                           out_vld_q;
  sitda_pkg::char_t               char_q;
  logic                           last_q;

  logic                           emit;
  logic                           is_last_c;
  logic                           ser_rdy;
  logic                           ser_take;
  logic [sitda_pkg::DIG_IW-1:0]   top_c;
  sitda_pkg::value_t              in_val;

  assign in_val = in_i.value[sitda_pkg::VALUE_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  always_comb begin
    stg_rdy[DD] = !vld_q[DD] || ser_rdy;
    for (int k = DD - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign in_i.ready = stg_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_rdy[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k <= DD; k++) begin
        if (stg_rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 0: sign and unsigned magnitude (the most negative value stays correct).
  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      neg_q[0] <= in_val[sitda_pkg::VALUE_BITS-1];
      bin_q[0] <= in_val[sitda_pkg::VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;
    end
  end

  // Double-dabble stages
  for (genvar k = 1; k <= DD; k++) begin : g_dd
    localparam int REM   = sitda_pkg::VALUE_BITS - (k - 1) * sitda_pkg::STEPS_PER_STAGE;
    localparam int NSTEP = (REM < sitda_pkg::STEPS_PER_STAGE) ? REM
                                                             : sitda_pkg::STEPS_PER_STAGE;
    sitda_pkg::bcd_t   bcd_in;
    sitda_pkg::bcd_t   bcd_c;
    sitda_pkg::value_t bin_c;

    if (k == 1) begin : g_first
      assign bcd_in = '0;
    end else begin : g_next
      assign bcd_in = bcd_q[k-1];
    end

    always_comb begin
      bcd_c = bcd_in;
      bin_c = bin_q[k-1];
      for (int i = 0; i < sitda_pkg::STEPS_PER_STAGE; i++) begin
        if (i < NSTEP) begin
          bcd_c = sitda_pkg::dd_step(bcd_c, bin_c[sitda_pkg::VALUE_BITS-1]);
          bin_c = bin_c << 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[k]) begin
        neg_q[k] <= neg_q[k-1];
        bin_q[k] <= bin_c;
        bcd_q[k] <= bcd_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Serializer: position of the leading nonzero digit, 0 for zero.
  always_comb begin
    top_c = '0;
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[DD][i] != 4'd0) top_c = sitda_pkg::DIG_IW'(i);
    end
  end

  assign emit      = busy_q && (!out_vld_q || out_o.ready);
  assign is_last_c = !neg_pend_q && (pos_q == '0);
  assign ser_rdy   = !busy_q || (emit && is_last_c);
  assign ser_take  = vld_q[DD] && ser_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      neg_pend_q <= 1'b0;
      pos_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      // a new number may load in the same cycle the last character leaves
      if (ser_take) begin
        busy_q     <= 1'b1;
        neg_pend_q <= neg_q[DD];
        pos_q      <= top_c;
      end else if (emit) begin
        if (neg_pend_q) begin
          neg_pend_q <= 1'b0;
        end else if (pos_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          pos_q <= pos_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take) dig_q <= bcd_q[DD];
    if (emit) begin
      char_q <= neg_pend_q ? sitda_pkg::CHAR_MINUS
                           : sitda_pkg::CHAR_ZERO + {2'b00, dig_q[pos_q]};
      last_q <= is_last_c;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

endmodule

// File: sv/sitda_checker.sv
// Port-level assertions for the decimal text unit and their bind.
module sitda_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  sitda_pkg::char_t  char_code_i,
  input  logic              last_char_i
);

  logic out_acc;
  logic first_q;  // next character starts a number
  logic minus_q;  // previous character was a minus sign

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      minus_q <= 1'b0;
    end else if (out_acc) begin
      first_q <= last_char_i;
      minus_q <= (char_code_i == sitda_pkg::CHAR_MINUS);
    end
  end

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(char_code_i) && $stable(last_char_i))
    else $error("output item changed while stalled");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_code_i == sitda_pkg::CHAR_MINUS) ||
                    (char_code_i >= sitda_pkg::CHAR_ZERO && char_code_i <= sitda_pkg::CHAR_NINE))
    else $error("character outside minus and digits");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_code_i == sitda_pkg::CHAR_MINUS |-> first_q && !last_char_i)
    else $error("minus sign not leading or ends a number");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (first_q || minus_q) && char_code_i == sitda_pkg::CHAR_ZERO |->
      last_char_i)
    else $error("leading zero digit");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .char_code_i (out_o.char_code),
  .last_char_i (out_o.last_char)
);

// File: tb/tb_top.sv
// Self-checking testbench for the signed integer to decimal ASCII text unit.
module tb_top;

  typedef struct {
    sitda_pkg::char_t code;
    logic             fin;
  } text_char_t;

  typedef struct {
    sitda_pkg::value_t value;
    int unsigned       gap;
  } int_job_t;

  logic   clk_i = 1'b0;
  logic   rst_n = 1'b0;

  logic              send_valid = 1'b0;
  sitda_pkg::value_t send_value = '0;
  logic              take_ready = 1'b0;

  sitda_in_if  in_if();
  sitda_out_if out_if();

  assign in_if.valid  = send_valid;
  assign in_if.value  = send_value;
  assign out_if.ready = take_ready;

  signed_int_to_decimal_ascii_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int_job_t    pending_ints[$];
  text_char_t  expected_chars[$];

  int unsigned ints_in     = 0;
  int unsigned chars_seen  = 0;
  int unsigned neg_ints    = 0;
  int unsigned full_length = 0;
  int unsigned errors      = 0;
  int unsigned total_ints  = 0;

  logic        in_taken   = 1'b0;
  logic        out_taken  = 1'b0;
  logic        stall_hold = 1'b0;

  // Appends the decimal text of v to the expected characters.
  function automatic void spell_decimal(input sitda_pkg::value_t v);
    sitda_pkg::value_t mag;
    logic              neg;
    sitda_pkg::char_t  text[$];
    neg = v[sitda_pkg::VALUE_BITS-1];
    mag = neg ? (~v + 1'b1) : v;  // unsigned, so the most negative value works
    do begin
      text.push_front(sitda_pkg::CHAR_ZERO + sitda_pkg::char_t'(mag % 10));
      mag = mag / 10;
    end while (mag != '0);
    if (neg) begin
      text.push_front(sitda_pkg::CHAR_MINUS);
      neg_ints++;
    end
    if (text.size() == 11) full_length++;
    foreach (text[i]) begin
      expected_chars.push_back('{code: text[i], fin: (i == text.size() - 1)});
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t, char %0d: %s got %0d want %0d", $time, chars_seen, what,
             got, want);
    errors++;
  endtask

  // Receiver stall pattern changes every 50 characters: random, none, sparse.
  function automatic int unsigned draw_rx_wait();
    case ((chars_seen / 50) % 3)
      0:       return $urandom_range(0, 13);
      1:       return 0;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  // Sampling at the rising edge: record handshakes, predict and check.
  always @(posedge clk_i) begin : watch
    text_char_t e;
    if (rst_n) begin
      in_taken  <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        spell_decimal(in_if.value);
        ints_in++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected char_code", int'(out_if.char_code), -1);
        end else begin
          e = expected_chars.pop_front();
          if (out_if.char_code !== e.code)
            report_mismatch("char_code", int'(out_if.char_code), int'(e.code));
          if (out_if.last_char !== e.fin)
            report_mismatch("last_char", int'(out_if.last_char), int'(e.fin));
        end
        chars_seen++;
      end
    end
  end

  // Sender: offers queued integers after each item's own gap.
  int_job_t    cur_job;
  logic        have_job = 1'b0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin : feed
    logic v;
    v = send_valid;
    if (rst_n) begin
      if (send_valid && in_taken) begin
        v        = 1'b0;
        have_job = 1'b0;
      end
      if (!have_job && pending_ints.size() != 0) begin
        cur_job  = pending_ints.pop_front();
        have_job = 1'b1;
        gap_left = cur_job.gap;
      end
      if (have_job && !v) begin
        if (gap_left != 0 && !stall_hold) gap_left--;
        else v = 1'b1;
      end
    end
    send_valid <= v;
    send_value <= have_job ? cur_job.value : send_value;
  end

  // Receiver: ready low for a drawn number of cycles before each character.
  int unsigned rx_wait = 0;

  always @(negedge clk_i) begin : drain
    logic r;
    r = 1'b0;
    if (rst_n) begin
      if (out_taken) rx_wait = draw_rx_wait();
      if (stall_hold) r = 1'b0;
      else if (rx_wait != 0) rx_wait--;
      else r = 1'b1;
    end
    take_ready <= r;
  end

  // Long receiver hold-off so the pipeline fills and input backs up.
  initial begin
    while (ints_in < 40) @(posedge clk_i);
    @(negedge clk_i);
    stall_hold <= 1'b1;
    repeat (250) @(negedge clk_i);
    stall_hold <= 1'b0;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int          specials[$];
    int unsigned raw;
    int unsigned lo;
    int unsigned hi;
    int unsigned nd;
    specials = {0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647, -2147483647,
                32'h8000_0000, 1000000000, -1000000000, 999999999, -999999999,
                123456789, -987654321, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F};
    foreach (specials[i]) begin
      pending_ints.push_back('{value: sitda_pkg::value_t'(specials[i]),
                               gap: $urandom_range(0, 13)});
    end
    for (int i = 0; i < 110; i++) begin
      case ($urandom_range(0, 3))
        0: raw = $urandom();
        1: begin
          // uniform over digit counts, random sign
          nd = $urandom_range(1, 10);
          lo = 1;
          for (int k = 1; k < nd; k++) lo = lo * 10;
          hi = (nd == 10) ? 32'd2147483647 : lo * 10 - 1;
          raw = $urandom_range(hi, lo);
          if ($urandom_range(0, 1) != 0) raw = -raw;
        end
        2:       raw = $urandom_range(0, 20) - 10;
        default: raw = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                   : 32'h8000_0000 + $urandom_range(0, 3);
      endcase
      // a run of back-to-back items in the middle of the random part
      pending_ints.push_back('{value: sitda_pkg::value_t'(raw),
                               gap: (i >= 40 && i < 75) ? 0 : $urandom_range(0, 13)});
    end
    total_ints = pending_ints.size();

    repeat (11) @(negedge clk_i);
    rst_n <= 1'b1;

    while (ints_in < total_ints) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Converted %0d integers (%0d negative, %0d at full 11-char length)",
             ints_in, neg_ints, full_length);
    $display("Checked %0d characters, including extremes, zero and a long output stall",
             chars_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
